>>> rtl/core/svr_pkg.sv
// ----------------------------------------------------------------------------
// svr_pkg: shared definitions of the serial attribute video renderer
// Operation and attribute codes, register indexes, reset values and the
// command record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package svr_pkg;

    localparam int COLUMNS_DEF      = 40;
    localparam int BITMAP_LINES_DEF = 200;
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam int STORE_DEPTH = 4096;
    localparam int STORE_AW    = 12;
    localparam int STORE_DW    = 8;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    // Operation codes.
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_LINE = 2'd1;
    localparam logic [1:0] OP_BYTE = 2'd2;

    // Attribute groups, bits 4..3 of an attribute byte.
    localparam logic [1:0] ATTR_FG    = 2'd0;
    localparam logic [1:0] ATTR_STYLE = 2'd1;
    localparam logic [1:0] ATTR_BG    = 2'd2;
    localparam logic [1:0] ATTR_MODE  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_HIRES_BASE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TEXT_BASE  = 1'd1;

    localparam logic [15:0] HIRES_BASE_RST = 16'd40960;
    localparam logic [15:0] TEXT_BASE_RST  = 16'd48000;
    localparam logic [2:0]  MODE_RST       = 3'd2;
    localparam logic [2:0]  FG_RST         = 3'd7;
    localparam logic [2:0]  BG_RST         = 3'd0;

    typedef enum logic [1:0] {
        K_NONE,    // result without pixels
        K_WRITE,   // character store write, result without pixels
        K_DIRECT,  // pixels from data carried in the command
        K_LOOKUP   // pixels from a character store read
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [STORE_AW-1:0]  ram_addr;
        logic [STORE_DW-1:0]  wr_data;
        logic [5:0]           data6;   // pixel bits, or the blank mask for a lookup
        logic [2:0]           fg;
        logic [2:0]           bg;
        logic [15:0]          fetch;
    } t_cmd;

endpackage

>>> rtl/core/svr_ram.sv
// ----------------------------------------------------------------------------
// svr_ram: generic single-port RAM
// One write and one read per cycle at a shared address; read data is
// registered and holds until the next read.
// ----------------------------------------------------------------------------
module svr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/svr_front.sv
// ----------------------------------------------------------------------------
// svr_front: item decoder and attribute state
// Accepts items, applies serial attributes, computes the fetch address and
// turns each item into one command for the back end.
// ----------------------------------------------------------------------------
module svr_front #(
    parameter int COLUMNS      = svr_pkg::COLUMNS_DEF,
    parameter int BITMAP_LINES = svr_pkg::BITMAP_LINES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [svr_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [svr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_accept,
    input  logic [1:0]                       i_operation,
    input  logic [11:0]                      i_charset_index,
    input  logic [7:0]                       i_charset_value,
    input  logic [7:0]                       i_line_y,
    input  logic                             i_blink_phase,
    input  logic [7:0]                       i_screen_byte,
    output svr_pkg::t_cmd                    o_cmd
);
    import svr_pkg::*;

    localparam int COL_W = $clog2(COLUMNS + 1);

    logic [15:0]      r_hires_base, r_text_base;
    logic [2:0]       r_mode, r_fg, r_bg, r_style, r_row;
    logic             r_hsel, r_blink;
    logic [COL_W-1:0] r_col;
    logic [7:0]       r_line;

    logic [2:0]       n_mode, n_fg, n_bg, n_style, n_row;
    logic             n_hsel, n_blink;
    logic [COL_W-1:0] n_col;
    logic [7:0]       n_line;

    logic        col_ok, is_attr, hires_now, hires_next;
    logic [5:0]  mask;
    logic [15:0] line_off, fetch_next;
    t_cmd        cmd;

    assign col_ok    = r_col < COL_W'(COLUMNS);
    assign is_attr   = (i_screen_byte[6:5] == 2'b00);
    assign mask      = (r_blink || !r_style[2]) ? 6'h3f : 6'h00;
    assign hires_now = (r_line < 8'(BITMAP_LINES)) && r_mode[2];

    always_comb begin
        n_mode  = r_mode;
        n_fg    = r_fg;
        n_bg    = r_bg;
        n_style = r_style;
        n_row   = r_row;
        n_hsel  = r_hsel;
        n_blink = r_blink;
        n_col   = r_col;
        n_line  = r_line;
        if (i_operation == OP_LINE) begin
            n_line  = i_line_y;
            n_blink = i_blink_phase;
            n_fg    = FG_RST;
            n_bg    = BG_RST;
            n_style = 3'd0;
            n_row   = i_line_y[2:0];
            n_col   = '0;
        end else if (i_operation == OP_BYTE && col_ok) begin
            n_col = r_col + COL_W'(1);
            if (is_attr) begin
                unique case (i_screen_byte[4:3])
                    ATTR_FG: n_fg = i_screen_byte[2:0];
                    ATTR_STYLE: begin
                        n_style = i_screen_byte[2:0];
                        n_row   = i_screen_byte[1] ? r_line[3:1] : r_line[2:0];
                    end
                    ATTR_BG: n_bg = i_screen_byte[2:0];
                    default: begin
                        n_mode = i_screen_byte[2:0];
                        n_hsel = i_screen_byte[2];
                    end
                endcase
            end
        end
    end

    // The address follows the state as it stands after this item.
    assign hires_next = (n_line < 8'(BITMAP_LINES)) && n_mode[2];
    assign line_off   = hires_next ? 16'(16'(n_line) * 16'(COLUMNS))
                                   : 16'(16'(n_line[7:3]) * 16'(COLUMNS));
    assign fetch_next = (hires_next ? r_hires_base : r_text_base) + line_off
                        + 16'(n_col);

    always_comb begin
        cmd          = '0;
        cmd.kind     = K_NONE;
        cmd.ram_addr = {r_hsel, r_style[0], i_screen_byte[6:0], r_row};
        unique case (i_operation)
            OP_LOAD: begin
                cmd.kind     = K_WRITE;
                cmd.ram_addr = i_charset_index;
                cmd.wr_data  = i_charset_value;
            end
            OP_LINE: begin
                cmd.fetch = fetch_next;
            end
            OP_BYTE: begin
                if (col_ok) begin
                    cmd.fetch = fetch_next;
                    cmd.fg    = n_fg ^ {3{i_screen_byte[7]}};
                    cmd.bg    = n_bg ^ {3{i_screen_byte[7]}};
                    if (is_attr) begin
                        cmd.kind  = K_DIRECT;
                        cmd.data6 = 6'h00;
                    end else if (hires_now) begin
                        cmd.kind  = K_DIRECT;
                        cmd.data6 = i_screen_byte[5:0] & mask;
                    end else begin
                        cmd.kind  = K_LOOKUP;
                        cmd.data6 = mask;
                    end
                end
            end
            default: cmd.kind = K_NONE;
        endcase
    end

    assign o_cmd = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hires_base <= HIRES_BASE_RST;
            r_text_base  <= TEXT_BASE_RST;
            r_mode       <= MODE_RST;
            r_fg         <= FG_RST;
            r_bg         <= BG_RST;
            r_style      <= 3'd0;
            r_row        <= 3'd0;
            r_hsel       <= 1'b0;
            r_blink      <= 1'b0;
            r_col        <= '0;
            r_line       <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_HIRES_BASE: r_hires_base <= i_cfg_data;
                    REG_TEXT_BASE:  r_text_base  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_mode  <= n_mode;
                r_fg    <= n_fg;
                r_bg    <= n_bg;
                r_style <= n_style;
                r_row   <= n_row;
                r_hsel  <= n_hsel;
                r_blink <= n_blink;
                r_col   <= n_col;
                r_line  <= n_line;
            end
        end
    end

endmodule

>>> rtl/core/svr_queue.sv
// ----------------------------------------------------------------------------
// svr_queue: command queue between front end and back end
// A small register FIFO; full and empty come straight from the count.
// ----------------------------------------------------------------------------
module svr_queue #(
    parameter int DEPTH = svr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  svr_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output svr_pkg::t_cmd o_cmd
);
    import svr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= wrap_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= wrap_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/core/svr_back.sv
// ----------------------------------------------------------------------------
// svr_back: command execution and pixel output
// Performs character store writes and reads in queue order, expands the
// six data bits into colours and holds the result in the output register.
// ----------------------------------------------------------------------------
module svr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  svr_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic          o_pixels_valid,
    output logic [2:0]    o_pixel_0,
    output logic [2:0]    o_pixel_1,
    output logic [2:0]    o_pixel_2,
    output logic [2:0]    o_pixel_3,
    output logic [2:0]    o_pixel_4,
    output logic [2:0]    o_pixel_5,
    output logic [15:0]   o_fetch_address
);
    import svr_pkg::*;

    t_cmd                r_a;
    logic                r_a_v;
    logic                r_b_v;
    logic                r_b_pv;
    logic [5:0][2:0]     r_b_pix;
    logic [15:0]         r_b_fetch;

    logic                can_b, pop, has_pix;
    logic [STORE_DW-1:0] ram_q;
    logic [5:0]          data;
    logic [5:0][2:0]     pix;

    assign can_b = !r_b_v || !i_stall;
    assign pop   = i_q_valid && (!r_a_v || can_b);

    svr_ram #(
        .WIDTH (STORE_DW),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (pop && i_q_cmd.kind == K_WRITE),
        .i_re    (pop && i_q_cmd.kind == K_LOOKUP),
        .i_addr  (i_q_cmd.ram_addr),
        .i_wdata (i_q_cmd.wr_data),
        .o_rdata (ram_q)
    );

    // For a lookup, data6 carries the blank mask.
    assign data    = (r_a.kind == K_LOOKUP) ? (ram_q[5:0] & r_a.data6) : r_a.data6;
    assign has_pix = (r_a.kind == K_DIRECT) || (r_a.kind == K_LOOKUP);

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            pix[i] = !has_pix ? 3'd0 : (data[5 - i] ? r_a.fg : r_a.bg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_a <= i_q_cmd;
        end
        if (can_b) begin
            r_b_pv    <= has_pix;
            r_b_pix   <= pix;
            r_b_fetch <= r_a.fetch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (pop) begin
                r_a_v <= 1'b1;
            end else if (can_b) begin
                r_a_v <= 1'b0;
            end
            if (can_b) begin
                r_b_v <= r_a_v;
            end
        end
    end

    assign o_q_pop         = pop;
    assign o_valid         = r_b_v;
    assign o_pixels_valid  = r_b_pv;
    assign o_pixel_0       = r_b_pix[0];
    assign o_pixel_1       = r_b_pix[1];
    assign o_pixel_2       = r_b_pix[2];
    assign o_pixel_3       = r_b_pix[3];
    assign o_pixel_4       = r_b_pix[4];
    assign o_pixel_5       = r_b_pix[5];
    assign o_fetch_address = r_b_fetch;

endmodule

>>> rtl/core/serial_attribute_video_byte_renderer_unit.sv
// Path: the command queue, then the back end's command and output registers.
// Throughput: one item per cycle while the output is not stalled, set by the
// single-port character store, which takes one write or one read each cycle.
// Reset: attribute state, base registers and queue pointers return to their
// reset values; the character store is not cleared and holds no valid bits.
// ----------------------------------------------------------------------------
// serial_attribute_video_byte_renderer_unit: top level
// Front end decodes items and tracks attributes, a command queue decouples
// it from the back end that accesses the character store and emits pixels.
// ----------------------------------------------------------------------------
module serial_attribute_video_byte_renderer_unit #(
    parameter int COLUMNS      = svr_pkg::COLUMNS_DEF,
    parameter int BITMAP_LINES = svr_pkg::BITMAP_LINES_DEF,
    parameter int QUEUE_DEPTH  = svr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [svr_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [svr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_operation,
    input  logic [11:0]                     i_charset_index,
    input  logic [7:0]                      i_charset_value,
    input  logic [7:0]                      i_line_y,
    input  logic                            i_blink_phase,
    input  logic [7:0]                      i_screen_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_pixels_valid,
    output logic [2:0]                      o_pixel_0,
    output logic [2:0]                      o_pixel_1,
    output logic [2:0]                      o_pixel_2,
    output logic [2:0]                      o_pixel_3,
    output logic [2:0]                      o_pixel_4,
    output logic [2:0]                      o_pixel_5,
    output logic [15:0]                     o_fetch_address
);
    import svr_pkg::*;

    logic accept, q_full, q_valid, q_pop;
    t_cmd front_cmd, q_cmd;

    assign accept     = i_in_valid && !q_full;
    assign o_in_stall = q_full;

    svr_front #(
        .COLUMNS      (COLUMNS),
        .BITMAP_LINES (BITMAP_LINES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_accept        (accept),
        .i_operation     (i_operation),
        .i_charset_index (i_charset_index),
        .i_charset_value (i_charset_value),
        .i_line_y        (i_line_y),
        .i_blink_phase   (i_blink_phase),
        .i_screen_byte   (i_screen_byte),
        .o_cmd           (front_cmd)
    );

    svr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    svr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_cmd         (q_cmd),
        .o_q_pop         (q_pop),
        .o_valid         (o_out_valid),
        .i_stall         (i_out_stall),
        .o_pixels_valid  (o_pixels_valid),
        .o_pixel_0       (o_pixel_0),
        .o_pixel_1       (o_pixel_1),
        .o_pixel_2       (o_pixel_2),
        .o_pixel_3       (o_pixel_3),
        .o_pixel_4       (o_pixel_4),
        .o_pixel_5       (o_pixel_5),
        .o_fetch_address (o_fetch_address)
    );

endmodule

>>> tb/sv/serial_attribute_video_byte_renderer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_attribute_video_byte_renderer_unit_test: self-checking testbench
// Drives charset loads, scanline starts and screen bytes into the renderer,
// predicts each pixel group and fetch address with a behavioral model of the
// attribute state or takes it from the table, and checks each result beat in
// order. A short directed table comes first, followed by random scanlines
// under several base register settings and random idling on both channels.
// ----------------------------------------------------------------------------
module serial_attribute_video_byte_renderer_unit_test;
    import svr_pkg::*;

    localparam int COLUMNS      = COLUMNS_DEF;
    localparam int BITMAP_LINES = BITMAP_LINES_DEF;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DIR_ROWS     = 28;

    // The block ignores this operation code; it still returns an empty beat.
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] idx;
        logic [7:0]  val;
        logic [7:0]  line;
        logic        blink;
        logic [7:0]  sbyte;
    } t_item;

    localparam int ITEM_W = $bits(t_item);

    typedef struct packed {
        logic            pix_valid;
        logic [0:5][2:0] pix;
        logic [15:0]     fetch;
    } t_pixels;

    typedef struct packed {
        t_item      it;
        logic [7:0] reps;
        logic       typed;
        t_pixels    want;
    } t_row;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_cfg_we        = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data      = '0;
    logic                   i_in_valid      = 1'b0;
    logic [1:0]             i_operation     = '0;
    logic [11:0]            i_charset_index = '0;
    logic [7:0]             i_charset_value = '0;
    logic [7:0]             i_line_y        = '0;
    logic                   i_blink_phase   = 1'b0;
    logic [7:0]             i_screen_byte   = '0;
    logic                   i_out_stall     = 1'b0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic                   o_pixels_valid;
    logic [2:0]             o_pixel_0;
    logic [2:0]             o_pixel_1;
    logic [2:0]             o_pixel_2;
    logic [2:0]             o_pixel_3;
    logic [2:0]             o_pixel_4;
    logic [2:0]             o_pixel_5;
    logic [15:0]            o_fetch_address;

    // Predicted renderer state.
    logic [15:0] hires_base = HIRES_BASE_RST;
    logic [15:0] text_base  = TEXT_BASE_RST;
    logic [2:0]  mode_reg   = MODE_RST;
    logic [2:0]  fg_col     = FG_RST;
    logic [2:0]  bg_col     = BG_RST;
    logic [2:0]  style      = '0;
    logic [2:0]  row        = '0;
    logic        hires_set  = 1'b0;
    logic [5:0]  col        = '0;
    logic [7:0]  cur_line   = '0;
    logic        blink_on   = 1'b0;
    logic [7:0]  glyph_rom   [STORE_DEPTH];
    bit          glyph_known [STORE_DEPTH];

    t_pixels     pending_groups [$];
    t_row        dir_tab [DIR_ROWS];
    int unsigned mismatches  = 0;
    int unsigned beats       = 0;
    int unsigned cycle_count = 0;
    bit          idle_on     = 1'b1;

    serial_attribute_video_byte_renderer_unit #(
        .COLUMNS      (COLUMNS),
        .BITMAP_LINES (BITMAP_LINES)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_charset_index (i_charset_index),
        .i_charset_value (i_charset_value),
        .i_line_y        (i_line_y),
        .i_blink_phase   (i_blink_phase),
        .i_screen_byte   (i_screen_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pixels_valid  (o_pixels_valid),
        .o_pixel_0       (o_pixel_0),
        .o_pixel_1       (o_pixel_1),
        .o_pixel_2       (o_pixel_2),
        .o_pixel_3       (o_pixel_3),
        .o_pixel_4       (o_pixel_4),
        .o_pixel_5       (o_pixel_5),
        .o_fetch_address (o_fetch_address)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit hires_line();
        return cur_line < BITMAP_LINES && mode_reg[2];
    endfunction

    function automatic logic [15:0] fetch_addr(input logic [5:0] at_col);
        int unsigned a;
        if (hires_line()) begin
            a = hires_base + cur_line * COLUMNS + at_col;
        end else begin
            a = text_base + (cur_line >> 3) * COLUMNS + at_col;
        end
        return 16'(a);
    endfunction

    function automatic logic [11:0] glyph_addr(input logic [7:0] c);
        return {hires_set, style[0], c[6:0], row};
    endfunction

    // Advances the predicted state by one accepted item and returns its beat.
    task automatic render_step(input t_item it, output t_pixels res);
        logic [7:0] c;
        logic [5:0] mask6;
        logic [5:0] data6;
        logic [2:0] fg;
        logic [2:0] bg;
        res = '0;
        case (it.op)
            OP_LOAD: begin
                glyph_rom[it.idx]   = it.val;
                glyph_known[it.idx] = 1'b1;
            end
            OP_LINE: begin
                cur_line  = it.line;
                blink_on  = it.blink;
                fg_col    = FG_RST;
                bg_col    = BG_RST;
                style     = '0;
                row       = it.line[2:0];
                col       = '0;
                res.fetch = fetch_addr(col);
            end
            OP_BYTE: begin
                if (col < COLUMNS) begin
                    c = it.sbyte;
                    // Blinking cells go blank unless the frame is in its shown phase.
                    mask6 = (blink_on || !style[2]) ? 6'h3f : 6'h00;
                    if (c[6:5] == 2'b00) begin
                        case (c[4:3])
                            ATTR_FG: fg_col = c[2:0];
                            ATTR_STYLE: begin
                                style = c[2:0];
                                row   = style[1] ? cur_line[3:1] : cur_line[2:0];
                            end
                            ATTR_BG: bg_col = c[2:0];
                            default: begin
                                mode_reg  = c[2:0];
                                hires_set = c[2];
                            end
                        endcase
                        data6 = '0;
                    end else if (hires_line()) begin
                        data6 = c[5:0] & mask6;
                    end else begin
                        data6 = glyph_rom[glyph_addr(c)][5:0] & mask6;
                    end
                    fg = fg_col ^ {3{c[7]}};
                    bg = bg_col ^ {3{c[7]}};
                    res.pix_valid = 1'b1;
                    for (int i = 0; i < 6; i++) begin
                        res.pix[i] = data6[5 - i] ? fg : bg;
                    end
                    col       = col + 6'd1;
                    res.fetch = fetch_addr(col);
                end
            end
            default: ;
        endcase
    endtask

    task automatic drive_beat(input t_item it, input bit typed, input t_pixels want);
        t_pixels calc;
        while (idle_on && $urandom_range(99) < 30) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_operation     <= it.op;
        i_charset_index <= it.idx;
        i_charset_value <= it.val;
        i_line_y        <= it.line;
        i_blink_phase   <= it.blink;
        i_screen_byte   <= it.sbyte;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        render_step(it, calc);
        pending_groups.push_back(typed ? want : calc);
        beats++;
    endtask

    // A character lookup must never hit a store entry that was never written,
    // so such a byte is preceded by a load of that entry.
    task automatic send_item(input t_item it, input bit typed, input t_pixels want);
        t_item fill;
        if (it.op == OP_BYTE && col < COLUMNS && it.sbyte[6:5] != 2'b00 && !hires_line()
            && !glyph_known[glyph_addr(it.sbyte)]) begin
            fill     = t_item'(ITEM_W'({$urandom, $urandom}));
            fill.op  = OP_LOAD;
            fill.idx = glyph_addr(it.sbyte);
            drive_beat(fill, 1'b0, '0);
        end
        drive_beat(it, typed, want);
    endtask

    task automatic write_bases(input logic [15:0] hires, input logic [15:0] text);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_HIRES_BASE;
        i_cfg_data  <= hires;
        @(posedge i_clk);
        i_cfg_index <= REG_TEXT_BASE;
        i_cfg_data  <= text;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        hires_base = hires;
        text_base  = text;
    endtask

    task automatic settle();
        while (pending_groups.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic void compare_field(input string what, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch on %s: expected %0d, got %0d", what, want, got);
            end
        end
    endfunction

    always @(posedge i_clk) begin : pixel_sink
        t_pixels want;
        t_pixels got;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_groups.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result beat arrived with nothing expected");
                    end
                end else begin
                    want = pending_groups.pop_front();
                    got  = {o_pixels_valid, o_pixel_0, o_pixel_1, o_pixel_2,
                            o_pixel_3, o_pixel_4, o_pixel_5, o_fetch_address};
                    compare_field("pixels_valid", 16'(want.pix_valid), 16'(got.pix_valid));
                    for (int i = 0; i < 6; i++) begin
                        compare_field($sformatf("pixel_%0d", i), 16'(want.pix[i]),
                                      16'(got.pix[i]));
                    end
                    compare_field("fetch_address", want.fetch, got.fetch);
                end
            end
            i_out_stall <= idle_on && ($urandom_range(99) < 30);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("serial_attribute_video_byte_renderer_unit_test NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        t_item it;
        int    nbytes;
        int    r;
        int    phase_end;

        dir_tab = '{
            // Attribute byte straight out of reset, before any scanline start.
            '{'{OP_BYTE, 12'h000, 8'h00, 8'd0, 1'b0, 8'h07}, 8'd1, 1'b1,
              '{1'b1, {6{3'd0}}, 16'd48001}},
            '{'{OP_LOAD, 12'h000, 8'hff, 8'd0, 1'b0, 8'h00}, 8'd1, 1'b1, '0},
            '{'{OP_LINE, 12'h000, 8'h00, 8'd0, 1'b0, 8'h00}, 8'd1, 1'b1,
              '{1'b0, {6{3'd0}}, 16'd48000}},
            '{'{OP_LOAD, 12'hfff, 8'h00, 8'd0, 1'b0, 8'h00}, 8'd1, 1'b1, '0},
            '{'{OP_LOAD, 12'h208, 8'h2a, 8'd0, 1'b0, 8'h00}, 8'd1, 1'b1, '0},
            '{'{OP_BYTE, 12'h000, 8'h00, 8'd0, 1'b0, 8'h41}, 8'd1, 1'b1,
              '{1'b1, {3'd7, 3'd0, 3'd7, 3'd0, 3'd7, 3'd0}, 16'd48001}},
            // Bit 7 inverts the foreground and background colours.
            '{'{OP_BYTE, 12'h000, 8'h00, 8'd0, 1'b0, 8'hc1}, 8'd1, 1'b1,
              '{1'b1, {3'd0, 3'd7, 3'd0, 3'd7, 3'd0, 3'd7}, 16'd48002}},
            '{'{OP_BYTE, 12'h000, 8'h00, 8'd0, 1'b0, 8'h11}, 8'd1, 1'b1,
              '{1'b1, {6{3'd1}}, 16'd48003}},
            '{'{OP_BYTE, 12'h000, 8'h00, 8'd0, 1'b0, 8'h02}, 8'd1, 1'b1,
              '{1'b1, {6{3'd1}}, 16'd48004}},
            '{'{OP_BYTE, 12'h000, 8'h00, 8'd0, 1'b0, 8'h80}, 8'd1, 1'b1,
              '{1'b1, {6{3'd6}}, 16'd48005}},
            '{'{OP_BYTE, 12'h000, 8'h00, 8'd0, 1'b0, 8'h0a}, 8'd1, 1'b0, '0},
            '{'{OP_LOAD, 12'h7ff, 8'hc0, 8'd0, 1'b0, 8'h00}, 8'd1, 1'b1, '0},
            // Blink style with the frame in its hidden phase.
            '{'{OP_BYTE, 12'h000, 8'h00, 8'd0, 1'b0, 8'h0c}, 8'd1, 1'b0, '0},
            '{'{OP_BYTE, 12'h000, 8'h00, 8'd0, 1'b0, 8'h41}, 8'd1, 1'b0, '0},
            '{'{OP_BYTE, 12'h000, 8'h00, 8'd0, 1'b0, 8'h09}, 8'd1, 1'b0, '0},
            '{'{OP_BYTE, 12'h000, 8'h00, 8'd0, 1'b0, 8'hff}, 8'd1, 1'b0, '0},
            // Mode 6 switches the line to hires.
            '{'{OP_BYTE, 12'h000, 8'h00, 8'd0, 1'b0, 8'h1e}, 8'd1, 1'b0, '0},
            '{'{OP_BYTE, 12'h000, 8'h00, 8'd0, 1'b0, 8'hff}, 8'd1, 1'b0, '0},
            '{'{OP_BYTE, 12'h000, 8'h00, 8'd0, 1'b0, 8'h20}, 8'd1, 1'b0, '0},
            '{'{OP_LINE, 12'h000, 8'h00, 8'd199, 1'b1, 8'h00}, 8'd1, 1'b1,
              '{1'b0, {6{3'd0}}, 16'd48920}},
            '{'{OP_BYTE, 12'h000, 8'h00, 8'd0, 1'b0, 8'h0c}, 8'd1, 1'b0, '0},
            '{'{OP_BYTE, 12'h000, 8'h00, 8'd0, 1'b0, 8'h3f}, 8'd1, 1'b0, '0},
            // Past the bitmap lines the hires mode renders text from the hires charset.
            '{'{OP_LINE, 12'h000, 8'h00, 8'd255, 1'b0, 8'h00}, 8'd1, 1'b1,
              '{1'b0, {6{3'd0}}, 16'd49240}},
            '{'{OP_BYTE, 12'h000, 8'h00, 8'd0, 1'b0, 8'h60}, 8'd1, 1'b0, '0},
            '{'{OP_SPARE, 12'hfff, 8'hff, 8'd255, 1'b1, 8'hff}, 8'd1, 1'b1, '0},
            '{'{OP_BYTE, 12'h000, 8'h00, 8'd0, 1'b0, 8'h1a}, 8'd1, 1'b0, '0},
            '{'{OP_LINE, 12'h000, 8'h00, 8'd100, 1'b0, 8'h00}, 8'd1, 1'b0, '0},
            // Runs past the last column, where bytes are ignored.
            '{'{OP_BYTE, 12'h000, 8'h00, 8'd0, 1'b0, 8'h13}, 8'd45, 1'b0, '0}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k]) begin
            repeat (dir_tab[k].reps) begin
                send_item(dir_tab[k].it, dir_tab[k].typed, dir_tab[k].want);
            end
        end
        i_in_valid <= 1'b0;
        settle();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       write_bases(16'h0000, 16'hffff);
                1:       write_bases(16'hffff, 16'h0000);
                default: write_bases(16'($urandom), 16'($urandom));
            endcase
            idle_on   = (phase != 2);
            phase_end = beats + PHASE_ITEMS;
            while (beats < phase_end) begin
                it      = t_item'(ITEM_W'({$urandom, $urandom}));
                it.op   = OP_LINE;
                it.line = ($urandom_range(99) < 85) ? 8'($urandom_range(0, 223))
                                                    : 8'($urandom_range(224, 255));
                send_item(it, 1'b0, '0);
                nbytes = ($urandom_range(99) < 90) ? $urandom_range(COLUMNS, COLUMNS + 3)
                                                   : $urandom_range(0, COLUMNS - 1);
                repeat (nbytes) begin
                    it = t_item'(ITEM_W'({$urandom, $urandom}));
                    r  = $urandom_range(99);
                    if (r < 4) begin
                        it.op = OP_LOAD;
                    end else if (r < 6) begin
                        it.op = OP_SPARE;
                    end else begin
                        it.op = OP_BYTE;
                        if (r < 30) begin
                            it.sbyte[6:5] = 2'b00;
                        end else if (it.sbyte[6:5] == 2'b00) begin
                            it.sbyte[6] = 1'b1;
                        end
                    end
                    send_item(it, 1'b0, '0);
                end
            end
            i_in_valid <= 1'b0;
            settle();
        end

        if (mismatches == 0 && pending_groups.size() == 0) begin
            $display("serial_attribute_video_byte_renderer_unit_test OK");
        end else begin
            $display("serial_attribute_video_byte_renderer_unit_test NOT OK");
        end
        $finish;
    end

endmodule
